/* sv/bps_pkg.sv */
`timescale 1ns / 1ps
// Package of the ballistic pitch solver: fixed-point constants, the CORDIC
// arctangent table and the command and status types between controller and datapath.
// No dependencies.
package bps_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int CORDIC_N    = 30;
    localparam int DIV_N       = 39;
    localparam int TOL         = ((1 << FRAC_BITS) + 50) / 100;
    localparam int HALF_PI     = 102944;
    localparam int CORDIC_GAIN = 652032874;

    localparam logic [5:0] CORDIC_LAST = 6'(CORDIC_N - 1);
    localparam logic [5:0] DIV_LAST    = 6'(DIV_N - 1);

    localparam logic REG_SPEED   = 1'b0;
    localparam logic REG_GRAVITY = 1'b1;

    localparam logic [22:0] SPEED_RESET   = 23'd1835008;
    localparam logic [20:0] GRAVITY_RESET = 21'd641512;

    localparam logic [31:0] ATAN_Q30 [CORDIC_N] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
    };

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD_IN,
        OP_ATAN_LOAD,
        OP_ATAN_STEP,
        OP_ROT_LOAD,
        OP_ROT_STEP,
        OP_MUL_VCOS,
        OP_MUL_VSIN,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_DIV_DONE,
        OP_MUL_TT,
        OP_MUL_RISE,
        OP_FALL_HI,
        OP_FALL_LO,
        OP_ERR,
        OP_OUT,
        OP_OUT_BAD
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ATAN_LOAD,
        ST_ATAN_ITER,
        ST_ROT_LOAD,
        ST_ROT_ITER,
        ST_MUL_VCOS,
        ST_MUL_VSIN,
        ST_DIV_LOAD,
        ST_DIV_ITER,
        ST_DIV_DONE,
        ST_MUL_TT,
        ST_MUL_RISE,
        ST_FALL_HI,
        ST_FALL_LO,
        ST_ERR,
        ST_DECIDE,
        ST_OUT,
        ST_OUT_BAD
    } state_t;

    typedef struct packed {
        dp_op_t     op;
        logic [5:0] step;
        logic [3:0] passes;
        logic       conv;
    } cmd_t;

    typedef struct packed {
        logic dist_bad;
        logic err_small;
        logic out_free;
    } status_t;

endpackage

/* sv/bps_ctrl.sv */
`timescale 1ns / 1ps
// Controller of the ballistic pitch solver: sequences the correction passes
// and issues datapath commands. Depends on bps_pkg.
module bps_ctrl #(
    parameter int MAX_PASSES = 10
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  bps_pkg::status_t status,
    output bps_pkg::cmd_t    cmd
);

    localparam int PASS_W = $clog2(MAX_PASSES + 1);

    bps_pkg::state_t    state_reg, state_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [PASS_W-1:0]  pass_reg, pass_next;
    logic               conv_reg, conv_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bps_pkg::ST_IDLE;
            cnt_reg   <= '0;
            pass_reg  <= '0;
            conv_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pass_reg  <= pass_next;
            conv_reg  <= conv_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bps_pkg::ST_IDLE:      if (s_tvalid) state_next = bps_pkg::ST_CHECK;
            bps_pkg::ST_CHECK:     state_next = status.dist_bad ? bps_pkg::ST_OUT_BAD
                                                                : bps_pkg::ST_ATAN_LOAD;
            bps_pkg::ST_ATAN_LOAD: state_next = bps_pkg::ST_ATAN_ITER;
            bps_pkg::ST_ATAN_ITER: if (cnt_reg == bps_pkg::CORDIC_LAST) begin
                state_next = bps_pkg::ST_ROT_LOAD;
            end
            bps_pkg::ST_ROT_LOAD:  state_next = bps_pkg::ST_ROT_ITER;
            bps_pkg::ST_ROT_ITER:  if (cnt_reg == bps_pkg::CORDIC_LAST) begin
                state_next = bps_pkg::ST_MUL_VCOS;
            end
            bps_pkg::ST_MUL_VCOS:  state_next = bps_pkg::ST_MUL_VSIN;
            bps_pkg::ST_MUL_VSIN:  state_next = bps_pkg::ST_DIV_LOAD;
            bps_pkg::ST_DIV_LOAD:  state_next = bps_pkg::ST_DIV_ITER;
            bps_pkg::ST_DIV_ITER:  if (cnt_reg == bps_pkg::DIV_LAST) begin
                state_next = bps_pkg::ST_DIV_DONE;
            end
            bps_pkg::ST_DIV_DONE:  state_next = bps_pkg::ST_MUL_TT;
            bps_pkg::ST_MUL_TT:    state_next = bps_pkg::ST_MUL_RISE;
            bps_pkg::ST_MUL_RISE:  state_next = bps_pkg::ST_FALL_HI;
            bps_pkg::ST_FALL_HI:   state_next = bps_pkg::ST_FALL_LO;
            bps_pkg::ST_FALL_LO:   state_next = bps_pkg::ST_ERR;
            bps_pkg::ST_ERR:       state_next = bps_pkg::ST_DECIDE;
            bps_pkg::ST_DECIDE: begin
                if (status.err_small || pass_reg == PASS_W'(MAX_PASSES)) begin
                    state_next = bps_pkg::ST_OUT;
                end else begin
                    state_next = bps_pkg::ST_ATAN_LOAD;
                end
            end
            bps_pkg::ST_OUT:       if (status.out_free) state_next = bps_pkg::ST_IDLE;
            bps_pkg::ST_OUT_BAD:   if (status.out_free) state_next = bps_pkg::ST_IDLE;
            default:               state_next = bps_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cnt_next  = cnt_reg;
        pass_next = pass_reg;
        conv_next = conv_reg;
        unique case (state_reg)
            bps_pkg::ST_CHECK: begin
                pass_next = '0;
                conv_next = 1'b0;
            end
            bps_pkg::ST_ATAN_LOAD, bps_pkg::ST_ROT_LOAD, bps_pkg::ST_DIV_LOAD: begin
                cnt_next = '0;
            end
            bps_pkg::ST_ATAN_ITER, bps_pkg::ST_ROT_ITER, bps_pkg::ST_DIV_ITER: begin
                cnt_next = cnt_reg + 6'd1;
            end
            bps_pkg::ST_ERR:    pass_next = pass_reg + PASS_W'(1);
            bps_pkg::ST_DECIDE: conv_next = status.err_small;
            default: ;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd.op     = bps_pkg::OP_NONE;
        cmd.step   = cnt_reg;
        cmd.conv   = conv_reg;
        cmd.passes = (32'(pass_reg) > 32'd15) ? 4'hF : 4'(pass_reg);
        unique case (state_reg)
            bps_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) cmd.op = bps_pkg::OP_LOAD_IN;
            end
            bps_pkg::ST_ATAN_LOAD: cmd.op = bps_pkg::OP_ATAN_LOAD;
            bps_pkg::ST_ATAN_ITER: cmd.op = bps_pkg::OP_ATAN_STEP;
            bps_pkg::ST_ROT_LOAD:  cmd.op = bps_pkg::OP_ROT_LOAD;
            bps_pkg::ST_ROT_ITER:  cmd.op = bps_pkg::OP_ROT_STEP;
            bps_pkg::ST_MUL_VCOS:  cmd.op = bps_pkg::OP_MUL_VCOS;
            bps_pkg::ST_MUL_VSIN:  cmd.op = bps_pkg::OP_MUL_VSIN;
            bps_pkg::ST_DIV_LOAD:  cmd.op = bps_pkg::OP_DIV_LOAD;
            bps_pkg::ST_DIV_ITER:  cmd.op = bps_pkg::OP_DIV_STEP;
            bps_pkg::ST_DIV_DONE:  cmd.op = bps_pkg::OP_DIV_DONE;
            bps_pkg::ST_MUL_TT:    cmd.op = bps_pkg::OP_MUL_TT;
            bps_pkg::ST_MUL_RISE:  cmd.op = bps_pkg::OP_MUL_RISE;
            bps_pkg::ST_FALL_HI:   cmd.op = bps_pkg::OP_FALL_HI;
            bps_pkg::ST_FALL_LO:   cmd.op = bps_pkg::OP_FALL_LO;
            bps_pkg::ST_ERR:       cmd.op = bps_pkg::OP_ERR;
            bps_pkg::ST_OUT:       if (status.out_free) cmd.op = bps_pkg::OP_OUT;
            bps_pkg::ST_OUT_BAD:   if (status.out_free) cmd.op = bps_pkg::OP_OUT_BAD;
            default: ;
        endcase
    end

endmodule

/* sv/bps_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the ballistic pitch solver: shared CORDIC, shared multiplier,
// restoring divider, configuration registers and the output register. Depends on bps_pkg.
module bps_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [22:0]       cfg_wdata,
    input  logic [47:0]       s_tdata,
    input  bps_pkg::cmd_t     cmd,
    output bps_pkg::status_t  status,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,
    output logic              m_tuser
);

    logic [22:0]         speed_reg;
    logic [20:0]         grav_reg;
    logic signed [23:0]  dist_reg, target_reg, aim_reg;
    logic signed [33:0]  cx_reg, cy_reg;
    logic signed [32:0]  cz_reg;
    logic signed [18:0]  ang_reg;
    logic signed [65:0]  prod_reg;
    logic [23:0]         vcos_reg;
    logic signed [24:0]  vsin_reg;
    logic [23:0]         rem_reg;
    logic [38:0]         quo_reg;
    logic [30:0]         t_reg;
    logic [39:0]         tt_reg;
    logic signed [47:0]  rise_reg;
    logic [61:0]         acc_reg;
    logic                err_small_reg;
    logic                m_tvalid_reg;
    logic [17:0]         pitch_reg;
    logic [3:0]          passes_reg;
    logic                conv_reg;
    logic                invalid_reg;

    logic signed [33:0]  shx, shy;
    logic signed [32:0]  atan_step;
    logic signed [32:0]  z_round;
    logic signed [18:0]  ang_round;
    logic signed [32:0]  mul_a, mul_b;
    logic signed [65:0]  mul_res;
    logic signed [32:0]  cos_clamp;
    logic [24:0]         div_sh;
    logic [24:0]         div_diff;
    logic [61:0]         fall_sum;
    logic [44:0]         fall;
    logic signed [49:0]  drop, err_full;
    logic signed [23:0]  err_sat, aim_sat;
    logic signed [24:0]  aim_sum;
    logic signed [17:0]  pitch_clamp;
    logic                out_free;

    assign shx       = cx_reg >>> cmd.step;
    assign shy       = cy_reg >>> cmd.step;
    assign atan_step = $signed({1'b0, bps_pkg::ATAN_Q30[cmd.step[4:0]]});
    assign z_round   = cz_reg + 33'sd8192;
    assign ang_round = z_round[32:14];
    assign cos_clamp = (cx_reg < 34'sd1) ? 33'sd1 : cx_reg[32:0];

    always_comb begin
        mul_a = $signed({10'b0, speed_reg});
        mul_b = cos_clamp;
        case (cmd.op)
            bps_pkg::OP_MUL_VSIN: mul_b = cy_reg[32:0];
            bps_pkg::OP_MUL_TT: begin
                mul_a = $signed({2'b0, t_reg});
                mul_b = $signed({2'b0, t_reg});
            end
            bps_pkg::OP_MUL_RISE: begin
                mul_a = $signed({{8{vsin_reg[24]}}, vsin_reg});
                mul_b = $signed({2'b0, t_reg});
            end
            bps_pkg::OP_FALL_HI: begin
                mul_a = $signed({12'b0, grav_reg});
                mul_b = $signed({13'b0, tt_reg[39:20]});
            end
            bps_pkg::OP_FALL_LO: begin
                mul_a = $signed({12'b0, grav_reg});
                mul_b = $signed({13'b0, tt_reg[19:0]});
            end
            default: ;
        endcase
    end

    assign mul_res = mul_a * mul_b;

    assign div_sh   = {rem_reg, quo_reg[38]};
    assign div_diff = div_sh - {1'b0, vcos_reg};

    assign fall_sum = acc_reg + {21'b0, prod_reg[40:0]};
    assign fall     = fall_sum[61:17];
    assign drop     = $signed({{2{rise_reg[47]}}, rise_reg}) - $signed({5'b0, fall});
    assign err_full = $signed({{26{target_reg[23]}}, target_reg}) - drop;

    always_comb begin
        if (err_full > 50'sd8388607) begin
            err_sat = 24'sh7FFFFF;
        end else if (err_full < -50'sd8388608) begin
            err_sat = 24'sh800000;
        end else begin
            err_sat = err_full[23:0];
        end
        aim_sum = $signed({aim_reg[23], aim_reg}) + $signed({err_sat[23], err_sat});
        if (aim_sum > 25'sd8388607) begin
            aim_sat = 24'sh7FFFFF;
        end else if (aim_sum < -25'sd8388608) begin
            aim_sat = 24'sh800000;
        end else begin
            aim_sat = aim_sum[23:0];
        end
        if (ang_reg > 19'(bps_pkg::HALF_PI)) begin
            pitch_clamp = 18'(bps_pkg::HALF_PI);
        end else if (ang_reg < -19'(bps_pkg::HALF_PI)) begin
            pitch_clamp = -18'(bps_pkg::HALF_PI);
        end else begin
            pitch_clamp = ang_reg[17:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg <= bps_pkg::SPEED_RESET;
            grav_reg  <= bps_pkg::GRAVITY_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == bps_pkg::REG_SPEED) begin
                speed_reg <= cfg_wdata;
            end else begin
                grav_reg <= cfg_wdata[20:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            bps_pkg::OP_LOAD_IN: begin
                dist_reg   <= s_tdata[23:0];
                target_reg <= s_tdata[47:24];
                aim_reg    <= s_tdata[47:24];
            end
            bps_pkg::OP_ATAN_LOAD: begin
                cx_reg <= {{4{dist_reg[23]}}, dist_reg, 6'b0};
                cy_reg <= {{4{aim_reg[23]}}, aim_reg, 6'b0};
                cz_reg <= '0;
            end
            bps_pkg::OP_ATAN_STEP: begin
                if (!cy_reg[33]) begin
                    cx_reg <= cx_reg + shy;
                    cy_reg <= cy_reg - shx;
                    cz_reg <= cz_reg + atan_step;
                end else begin
                    cx_reg <= cx_reg - shy;
                    cy_reg <= cy_reg + shx;
                    cz_reg <= cz_reg - atan_step;
                end
            end
            bps_pkg::OP_ROT_LOAD: begin
                ang_reg <= ang_round;
                cx_reg  <= 34'(bps_pkg::CORDIC_GAIN);
                cy_reg  <= '0;
                cz_reg  <= {ang_round, 14'b0};
            end
            bps_pkg::OP_ROT_STEP: begin
                if (!cz_reg[32]) begin
                    cx_reg <= cx_reg - shy;
                    cy_reg <= cy_reg + shx;
                    cz_reg <= cz_reg - atan_step;
                end else begin
                    cx_reg <= cx_reg + shy;
                    cy_reg <= cy_reg - shx;
                    cz_reg <= cz_reg + atan_step;
                end
            end
            bps_pkg::OP_MUL_VCOS: prod_reg <= mul_res;
            bps_pkg::OP_MUL_VSIN: begin
                vcos_reg <= (prod_reg[53:30] == 24'd0) ? 24'd1 : prod_reg[53:30];
                prod_reg <= mul_res;
            end
            bps_pkg::OP_DIV_LOAD: begin
                vsin_reg <= prod_reg[54:30];
                rem_reg  <= '0;
                quo_reg  <= {dist_reg[22:0], 16'b0};
            end
            bps_pkg::OP_DIV_STEP: begin
                if (!div_diff[24]) begin
                    rem_reg <= div_diff[23:0];
                    quo_reg <= {quo_reg[37:0], 1'b1};
                end else begin
                    rem_reg <= div_sh[23:0];
                    quo_reg <= {quo_reg[37:0], 1'b0};
                end
            end
            bps_pkg::OP_DIV_DONE: begin
                t_reg <= (|quo_reg[38:31]) ? '1 : quo_reg[30:0];
            end
            bps_pkg::OP_MUL_TT: prod_reg <= mul_res;
            bps_pkg::OP_MUL_RISE: begin
                tt_reg   <= (|prod_reg[65:56]) ? '1 : prod_reg[55:16];
                prod_reg <= mul_res;
            end
            bps_pkg::OP_FALL_HI: begin
                rise_reg <= prod_reg[63:16];
                prod_reg <= mul_res;
            end
            bps_pkg::OP_FALL_LO: begin
                acc_reg  <= {prod_reg[41:0], 20'b0};
                prod_reg <= mul_res;
            end
            bps_pkg::OP_ERR: begin
                aim_reg       <= aim_sat;
                err_small_reg <= (err_sat > -24'(bps_pkg::TOL)) &&
                                 (err_sat < 24'(bps_pkg::TOL));
            end
            default: ;
        endcase
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.op == bps_pkg::OP_OUT || cmd.op == bps_pkg::OP_OUT_BAD) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == bps_pkg::OP_OUT) begin
            pitch_reg   <= pitch_clamp;
            passes_reg  <= cmd.passes;
            conv_reg    <= cmd.conv;
            invalid_reg <= 1'b0;
        end else if (cmd.op == bps_pkg::OP_OUT_BAD) begin
            pitch_reg   <= '0;
            passes_reg  <= '0;
            conv_reg    <= 1'b0;
            invalid_reg <= 1'b1;
        end
    end

    assign status.dist_bad  = dist_reg[23] || (dist_reg == 24'sd0);
    assign status.err_small = err_small_reg;
    assign status.out_free  = out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, conv_reg, passes_reg, pitch_reg};
    assign m_tuser  = invalid_reg;

endmodule

/* sv/ballistic_pitch_solver_core.sv */
`timescale 1ns / 1ps
// Top level of the ballistic pitch solver: joins the controller and the datapath.
// Depends on bps_pkg, bps_ctrl and bps_datapath.
//
// The input channel takes one word holding the target's horizontal distance and
// height in signed Q8.16 metres. For each word the block returns one result word
// with the launch pitch in signed Q2.16 radians, the number of correction passes
// run and a converged flag; m_tuser is high when the distance was zero or negative.
// Each pass runs a 30-step arctangent CORDIC, a 30-step sine/cosine CORDIC on the
// same shared unit, a 39-step restoring divider for flight time and the products
// for the velocity components, the squared flight time, the rise and the fall on
// one shared multiplier; an item runs up to MAX_PASSES passes. An invalid
// distance is answered without a pass. One item is in work at a time; s_tready is high only
// while the block waits for a word. The result sits in an output register, so a new
// word is taken while the previous result still waits; the block stalls before
// writing the next result until the receiver takes the old one.
// The configuration port writes muzzle speed (index 0) and gravity (index 1) and
// should only be used while the block is idle. Reset clears control state and
// loads both registers with their defaults; no result is pending after reset.
module ballistic_pitch_solver_core #(
    parameter int MAX_PASSES = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [22:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // horizontal_distance [23:0], target_height [47:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // pitch_angle [17:0], passes_used [21:18], converged [22]
    output logic        m_tuser    // invalid_input
);

    bps_pkg::cmd_t    cmd;
    bps_pkg::status_t status;

    bps_ctrl #(
        .MAX_PASSES(MAX_PASSES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bps_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 24'd0)
        else $error("invalid result carries nonzero data");

    a_passes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[21:18] != 4'd0)
        else $error("valid result reports no passes");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while one is in work");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[17:0]) <= 18'sd102944 &&
                     $signed(m_tdata[17:0]) >= -18'sd102944)
        else $error("pitch outside half pi");

endmodule
